/* design/sxmc_pkg.sv */
// Shared constants for the subarray XOR match counter.
package sxmc_pkg;

    localparam int unsigned TARGET_BITS   = 8;
    localparam int unsigned APB_DATA_BITS = 32;
    localparam int unsigned APB_ADDR_BITS = 3;
    localparam int unsigned OUT_BITS      = 32;

    typedef enum logic [0:0] {
        REG_TARGET_XOR = 1'b0
    } reg_index_t;

endpackage

/* design/sxmc_table.sv */
// Prefix tally memory with two registered read ports and one write port.
module sxmc_table #(
    parameter int unsigned ADDR_BITS = 8,
    parameter int unsigned DATA_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr_a,
    input  logic [ADDR_BITS-1:0] rd_addr_b,
    output logic [DATA_BITS-1:0] rd_data_a,
    output logic [DATA_BITS-1:0] rd_data_b,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data
);

    localparam int unsigned DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

/* design/subarray_xor_match_counter_top.sv */
// Top level of the subarray XOR match counter.
// A request is held in the update stage, then its result in the output register.
// Throughput: one request per cycle while the output is not stalled; the tally memory
// reads at acceptance and writes back from the update stage, forwarded to overlapping reads.
// Reset clears the prefix, the total, all tally valid bits and target_xor;
// no clearing pass is needed, so requests are taken from the first cycle.
module subarray_xor_match_counter_top #(
    parameter int unsigned VALUE_BITS = 8,
    parameter int unsigned TALLY_BITS = 16,
    parameter int unsigned TOTAL_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sxmc_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [sxmc_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [sxmc_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           element_value,
    input  logic                                 restart,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sxmc_pkg::OUT_BITS-1:0]        matching_total
);

    localparam int unsigned DEPTH = 1 << VALUE_BITS;
    localparam int unsigned EW = (VALUE_BITS > sxmc_pkg::TARGET_BITS) ?
                                 VALUE_BITS : sxmc_pkg::TARGET_BITS;
    localparam int unsigned SW = ((TOTAL_BITS > TALLY_BITS + 1) ?
                                  TOTAL_BITS : TALLY_BITS + 1) + 1;

    logic [sxmc_pkg::TARGET_BITS-1:0] target_reg;
    logic                             cfg_write;

    logic [VALUE_BITS-1:0] prefix_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    logic [DEPTH-1:0]      tally_valid_reg;
    logic [DEPTH-1:0]      tally_valid_next;

    logic                  s1_valid_reg;
    logic [VALUE_BITS-1:0] s1_prefix_reg;
    logic [VALUE_BITS-1:0] s1_lookup_reg;
    logic                  s1_restart_reg;
    logic                  s1_fwd_lookup_reg;
    logic                  s1_fwd_prefix_reg;
    logic [TALLY_BITS-1:0] s1_fwd_data_reg;

    logic                  out_valid_reg;
    logic [sxmc_pkg::OUT_BITS-1:0] out_total_reg;

    logic                  in_acc;
    logic                  s1_adv;
    logic [EW-1:0]         elem_ext;
    logic [EW-1:0]         tgt_ext;
    logic [VALUE_BITS-1:0] tgt_val;
    logic                  tgt_in_range;
    logic [VALUE_BITS-1:0] prefix_base;
    logic [VALUE_BITS-1:0] new_prefix;
    logic [VALUE_BITS-1:0] lookup_addr;

    logic [TALLY_BITS-1:0] rd_data_a;
    logic [TALLY_BITS-1:0] rd_data_b;
    logic                  wr_en;
    logic [TALLY_BITS-1:0] wr_data;

    logic [TALLY_BITS-1:0] lookup_raw;
    logic [TALLY_BITS-1:0] cur_raw;
    logic [TALLY_BITS-1:0] lookup_cnt;
    logic [TALLY_BITS-1:0] cur_cnt;
    logic                  prefix_eq;
    logic [TOTAL_BITS-1:0] total_base;
    logic [SW-1:0]         sum_wide;
    logic [TOTAL_BITS-1:0] total_new;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == sxmc_pkg::REG_TARGET_XOR);
    assign prdata    = sxmc_pkg::APB_DATA_BITS'(target_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_write)
        begin
            target_reg <= pwdata[sxmc_pkg::TARGET_BITS-1:0];
        end
    end

    // Handshake control.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_acc   = in_valid && in_ready;

    // Acceptance stage: new prefix and table addresses.
    assign elem_ext     = EW'(element_value);
    assign tgt_ext      = EW'(target_reg);
    assign tgt_in_range = ((tgt_ext >> VALUE_BITS) == '0);
    assign tgt_val      = tgt_ext[VALUE_BITS-1:0];
    assign prefix_base  = restart ? '0 : prefix_reg;
    assign new_prefix   = prefix_base ^ elem_ext[VALUE_BITS-1:0];
    assign lookup_addr  = new_prefix ^ tgt_val;

    sxmc_table #(
        .ADDR_BITS (VALUE_BITS),
        .DATA_BITS (TALLY_BITS)
    ) u_table (
        .clk       (clk),
        .rd_en     (in_acc),
        .rd_addr_a (lookup_addr),
        .rd_addr_b (new_prefix),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (wr_en),
        .wr_addr   (s1_prefix_reg),
        .wr_data   (wr_data)
    );

    // Update stage: the write-back of this cycle is forwarded to the request
    // that reads the table at the same edge.
    assign lookup_raw = s1_fwd_lookup_reg ? s1_fwd_data_reg : rd_data_a;
    assign cur_raw    = s1_fwd_prefix_reg ? s1_fwd_data_reg : rd_data_b;
    assign lookup_cnt = (tgt_in_range && !s1_restart_reg &&
                         tally_valid_reg[s1_lookup_reg]) ? lookup_raw : '0;
    assign cur_cnt    = (!s1_restart_reg && tally_valid_reg[s1_prefix_reg]) ?
                        cur_raw : '0;
    assign prefix_eq  = tgt_in_range && (s1_prefix_reg == tgt_val);
    assign total_base = s1_restart_reg ? '0 : total_reg;
    assign sum_wide   = SW'(total_base) + SW'(lookup_cnt) + SW'(prefix_eq);
    assign total_new  = (sum_wide > SW'({TOTAL_BITS{1'b1}})) ?
                        {TOTAL_BITS{1'b1}} : sum_wide[TOTAL_BITS-1:0];
    assign wr_en      = s1_adv;
    assign wr_data    = (cur_cnt == {TALLY_BITS{1'b1}}) ? cur_cnt :
                        cur_cnt + TALLY_BITS'(1);

    always_comb
    begin
        tally_valid_next = tally_valid_reg;
        if (s1_adv)
        begin
            if (s1_restart_reg)
            begin
                tally_valid_next = '0;
            end
            tally_valid_next[s1_prefix_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg      <= '0;
            total_reg       <= '0;
            tally_valid_reg <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            tally_valid_reg <= tally_valid_next;
            if (in_acc)
            begin
                prefix_reg <= new_prefix;
            end
            if (s1_adv)
            begin
                total_reg <= total_new;
            end
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_prefix_reg     <= new_prefix;
            s1_lookup_reg     <= lookup_addr;
            s1_restart_reg    <= restart;
            s1_fwd_lookup_reg <= wr_en && (s1_prefix_reg == lookup_addr);
            s1_fwd_prefix_reg <= wr_en && (s1_prefix_reg == new_prefix);
            s1_fwd_data_reg   <= wr_data;
        end
        if (s1_adv)
        begin
            out_total_reg <= sxmc_pkg::OUT_BITS'(total_new);
        end
    end

    assign out_valid      = out_valid_reg;
    assign matching_total = out_total_reg;

    // The input side stalls only when both stages hold work and the output waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a full pipeline");

    // A written entry is marked valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> tally_valid_reg[$past(s1_prefix_reg)])
        else $error("tally entry not valid after write-back");

    // A restart leaves exactly one valid entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_restart_reg) |=> ($countones(tally_valid_reg) == 1))
        else $error("restart did not clear the tally valid bits");

    // Within one array the running total never decreases.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_restart_reg) |=> (total_reg >= $past(total_reg)))
        else $error("running total decreased");

endmodule

/* tb/tb_subarray_xor_match_counter_top.sv */
// Self-checking testbench for the subarray XOR match counter with APB target setup.
module tb_subarray_xor_match_counter_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [sxmc_pkg::APB_ADDR_BITS-1:0] TARGET_ADDR =
        sxmc_pkg::APB_ADDR_BITS'(4 * sxmc_pkg::REG_TARGET_XOR);
    localparam longint unsigned TOTAL_MAX = 64'hFFFF_FFFF;
    localparam logic [15:0] TALLY_MAX = 16'hFFFF;
    localparam int DIRECTED_ROWS = 20;
    localparam int PHASES = 6;
    localparam int PHASE_REQUESTS = 100;
    localparam int BURST_REQUESTS = 16;

    typedef struct packed {
        logic [7:0]  elem;
        logic        rs;
        logic        typed;
        logic [31:0] total;
    } step_row_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [sxmc_pkg::APB_ADDR_BITS-1:0]   paddr = '0;
    logic [sxmc_pkg::APB_DATA_BITS-1:0]   pwdata = '0;
    logic [sxmc_pkg::APB_DATA_BITS-1:0]   prdata;
    logic                                 pready;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic [7:0]                           element_value = '0;
    logic                                 restart = 1'b0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic [sxmc_pkg::OUT_BITS-1:0]        matching_total;

    logic [7:0]  target_now = '0;
    logic [7:0]  prefix_now = '0;
    logic [31:0] total_now = '0;
    logic [15:0] prefix_count [256];
    bit   [255:0] count_seen = '0;

    logic [31:0] total_queue [$];
    int          mismatch_count = 0;
    bit          feed_idle = 1'b0;
    bit          drain_idle = 1'b0;
    bit          long_hold = 1'b0;

    step_row_t directed_steps [0:DIRECTED_ROWS-1] = '{
        '{8'h00, 1'b0, 1'b1, 32'd1},
        '{8'h00, 1'b0, 1'b1, 32'd3},
        '{8'hFF, 1'b0, 1'b1, 32'd3},
        '{8'hFF, 1'b0, 1'b1, 32'd6},
        '{8'h80, 1'b1, 1'b1, 32'd0},
        '{8'h80, 1'b0, 1'b1, 32'd1},
        '{8'h01, 1'b0, 1'b1, 32'd1},
        '{8'h01, 1'b0, 1'b1, 32'd3},
        '{8'hAA, 1'b1, 1'b1, 32'd0},
        '{8'h55, 1'b0, 1'b1, 32'd0},
        '{8'hFF, 1'b0, 1'b1, 32'd1},
        '{8'h00, 1'b1, 1'b1, 32'd1},
        '{8'h7F, 1'b0, 1'b0, 32'd0},
        '{8'h80, 1'b0, 1'b0, 32'd0},
        '{8'h01, 1'b0, 1'b0, 32'd0},
        '{8'hFE, 1'b0, 1'b0, 32'd0},
        '{8'h3C, 1'b0, 1'b0, 32'd0},
        '{8'hC3, 1'b0, 1'b0, 32'd0},
        '{8'hFF, 1'b1, 1'b0, 32'd0},
        '{8'hFF, 1'b0, 1'b0, 32'd0}
    };

    logic [7:0] phase_target [0:PHASES-1] = '{8'h03, 8'hFF, 8'h80, 8'h05, 8'h00, 8'h00};
    logic [7:0] phase_mask   [0:PHASES-1] = '{8'h03, 8'hFF, 8'h81, 8'h0F, 8'h07, 8'h1F};

    subarray_xor_match_counter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .matching_total(matching_total)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] count_matches(input logic [7:0] elem, input logic rs);
        longint unsigned add;
        logic [7:0]      partner;
        logic [15:0]     cur;
        if (rs)
        begin
            prefix_now = '0;
            total_now = '0;
            count_seen = '0;
        end
        prefix_now = prefix_now ^ elem;
        partner = prefix_now ^ target_now;
        add = count_seen[partner] ? longint'(prefix_count[partner]) : 0;
        if (prefix_now == target_now)
            add = add + 1;
        if (add > TOTAL_MAX - longint'(total_now))
            total_now = 32'hFFFF_FFFF;
        else
            total_now = total_now + 32'(add);
        cur = count_seen[prefix_now] ? prefix_count[prefix_now] : 16'd0;
        if (cur < TALLY_MAX)
            cur = cur + 16'd1;
        prefix_count[prefix_now] = cur;
        count_seen[prefix_now] = 1'b1;
        return total_now;
    endfunction

    task automatic send_element(input logic [7:0] elem, input logic rs, input logic typed,
                                input logic [31:0] typed_total);
        int          gap;
        logic [31:0] predicted;
        gap = feed_idle ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        element_value <= elem;
        restart <= rs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = count_matches(elem, rs);
        total_queue.push_back(typed ? typed_total : predicted);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (total_queue.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_target(input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TARGET_ADDR;
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        target_now = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[7:0] !== value)
        begin
            $display("%0t: target_xor readback expected %0d, got %0d", $time, value,
                     prdata[7:0]);
            mismatch_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (total_queue.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %0d", $time,
                         matching_total);
                mismatch_count++;
            end
            else
            begin
                want = total_queue.pop_front();
                if (matching_total !== want)
                begin
                    $display("%0t: matching_total expected %0d, got %0d", $time, want,
                             matching_total);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int stall;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            stall = drain_idle ? $urandom_range(0, 18) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        logic [7:0] mask;
        logic [7:0] elem;
        logic       rs;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_element(directed_steps[i].elem, directed_steps[i].rs, directed_steps[i].typed,
                         directed_steps[i].total);
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            mask = phase_mask[p];
            write_target(p == PHASES - 1 ? 8'($urandom) & mask : phase_target[p]);
            feed_idle = (p % 3) != 0;
            drain_idle = (p % 3) != 1;
            if (p == 0)
                long_hold = 1'b1;
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                elem = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom) & mask;
                rs = (i == 0) || ($urandom_range(0, 39) == 0);
                send_element(elem, rs, 1'b0, '0);
            end
            drain_results();
        end

        write_target(8'h00);
        feed_idle = 1'b0;
        drain_idle = 1'b0;
        for (int i = 0; i < BURST_REQUESTS; i++)
            send_element(8'h00, i == 0, 1'b0, '0);
        drain_results();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && total_queue.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

/* filelist.f */
design/sxmc_pkg.sv
design/sxmc_table.sv
design/subarray_xor_match_counter_top.sv
tb/tb_subarray_xor_match_counter_top.sv
